### rtl/polygon_normal_degeneracy_defines.svh
// ----------------------------------------------------------------------------
// Polygon normal degeneracy - assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLYGON_NORMAL_DEGENERACY_DEFINES_SVH
`define POLYGON_NORMAL_DEGENERACY_DEFINES_SVH

// same-cycle implication
`define PND_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PND_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pnd_pkg.sv
// ----------------------------------------------------------------------------
// pnd_pkg
// Shared constants and the ring summary passed from front end to back end.
// ----------------------------------------------------------------------------
package pnd_pkg;

    localparam int COORD_W      = 16;
    localparam int MAX_VERTICES = 256;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int MIN_VERTS    = 3;
    localparam int NUM_AXES     = 3;
    localparam int AXIS_W       = $clog2(NUM_AXES);
    localparam int SUM_W        = 42;
    localparam int OUT_W        = 41;
    localparam int PROD_W       = 2 * (COORD_W + 1);
    localparam int EXT_W        = COORD_W;
    localparam int TOL_W        = 32;
    localparam int MUL_W        = 32;
    localparam int NSQ_W        = 2 * SUM_W;
    localparam int RSQ_W        = 4 * MUL_W;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(4295);
    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

    typedef struct packed {
        logic [NUM_AXES-1:0][SUM_W-1:0] normal;
        logic [EXT_W-1:0]               extent;
        logic                           few;
        logic                           overflowed;
    } t_summary;

endpackage

### rtl/polygon_normal_degeneracy.sv
// ----------------------------------------------------------------------------
// polygon_normal_degeneracy - Newell polygon normal with degeneracy flag
// Throughput: one vertex per cycle within a ring; input stalls after the last vertex while the
// ring is closed and its summary pushed, longer while the queue is full.
// Result: the back end outputs short, zero-extent or too-long rings once popped, others after
// 14 steps on its shared 32x32 multiplier and a compare; it holds one ring at a time.
// Reset: synchronous active low; clears the ring, the queue, tolerance to 4295.
// ----------------------------------------------------------------------------
`include "polygon_normal_degeneracy_defines.svh"

module polygon_normal_degeneracy import pnd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [TOL_W-1:0]          i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic                      i_last_vertex,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [OUT_W-1:0]   o_normal_x,
    output logic signed [OUT_W-1:0]   o_normal_y,
    output logic signed [OUT_W-1:0]   o_normal_z,
    output logic                      o_degenerate,
    output logic                      o_too_long
);

    logic [TOL_W-1:0] r_tol;
    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_empty;
    t_summary         w_q_in;
    t_summary         w_q_out;
    logic             w_last_acc;
    logic             w_nrm_zero;

    assign w_last_acc = i_valid && !o_stall && i_last_vertex;
    assign w_nrm_zero = (o_normal_x == '0) && (o_normal_y == '0) && (o_normal_z == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_wr_en) begin
            r_tol <= i_cfg_wr_data;
        end
    end

    pnd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_last_vertex (i_last_vertex),
        .o_push        (w_push),
        .o_summary     (w_q_in),
        .i_full        (w_full)
    );

    pnd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    pnd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_summary    (w_q_out),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .i_tol        (r_tol),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_degenerate (o_degenerate),
        .o_too_long   (o_too_long)
    );

    `PND_ASSERT_IMP(a_push_room, w_push, !w_full, "summary pushed into a full queue")
    `PND_ASSERT_IMP(a_pop_data, w_pop, !w_empty, "summary popped from an empty queue")
    `PND_ASSERT_NXT(a_close_stall, w_last_acc, o_stall, "no stall after last vertex")
    `PND_ASSERT_IMP(a_long_degen, o_valid && o_too_long, o_degenerate && w_nrm_zero, "long ring")

endmodule

### rtl/pnd_front.sv
// ----------------------------------------------------------------------------
// pnd_front
// Vertex intake: Newell edge products, normal sums, bounding box, closing
// edge, and one summary per ring pushed into the queue.
// ----------------------------------------------------------------------------
module pnd_front import pnd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic                      i_last_vertex,
    output logic                      o_push,
    output t_summary                  o_summary,
    input  logic                      i_full
);

    typedef enum logic [3:0] {
        F_RUN   = 4'b0001,
        F_CLOSE = 4'b0010,
        F_DRAIN = 4'b0100,
        F_PUSH  = 4'b1000
    } t_fstate;

    t_fstate                   r_state;
    t_fstate                   n_state;
    logic signed [COORD_W-1:0] r_first [NUM_AXES];
    logic signed [COORD_W-1:0] r_prev  [NUM_AXES];
    logic signed [COORD_W-1:0] r_min   [NUM_AXES];
    logic signed [COORD_W-1:0] r_max   [NUM_AXES];
    logic        [SUM_W-1:0]   r_sum   [NUM_AXES];
    logic signed [PROD_W-1:0]  r_prod  [NUM_AXES];
    logic                      r_prod_vld;
    logic        [CNT_W-1:0]   r_count;
    logic                      r_ovf;

    logic signed [COORD_W-1:0] w_pt   [NUM_AXES];
    logic signed [COORD_W-1:0] w_nxt  [NUM_AXES];
    logic signed [COORD_W:0]   w_dif  [NUM_AXES];
    logic signed [COORD_W:0]   w_add  [NUM_AXES];
    logic signed [PROD_W-1:0]  w_pr   [NUM_AXES];
    logic        [EXT_W-1:0]   w_side [NUM_AXES];
    logic        [EXT_W-1:0]   w_ext01;
    logic        [EXT_W-1:0]   w_ext;
    logic                      w_accept;
    logic                      w_cnt_full;
    logic                      w_take;
    logic                      w_prod_en;

    assign w_pt[0] = i_coord_x;
    assign w_pt[1] = i_coord_y;
    assign w_pt[2] = i_coord_z;

    assign o_stall    = (r_state != F_RUN);
    assign w_accept   = i_valid && (r_state == F_RUN);
    assign w_cnt_full = (r_count == CNT_W'(MAX_VERTICES));
    assign w_take     = w_accept && !w_cnt_full;
    assign w_prod_en  = (w_take && (r_count != '0)) || ((r_state == F_CLOSE) && !r_ovf);
    assign o_push     = (r_state == F_PUSH) && !i_full;

    // edge from previous vertex to either the new vertex or the first one
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            w_nxt[k] = (r_state == F_CLOSE) ? r_first[k] : w_pt[k];
            w_dif[k] = {r_prev[k][COORD_W-1], r_prev[k]} - {w_nxt[k][COORD_W-1], w_nxt[k]};
            w_add[k] = {r_prev[k][COORD_W-1], r_prev[k]} + {w_nxt[k][COORD_W-1], w_nxt[k]};
        end
        w_pr[0] = w_dif[1] * w_add[2];
        w_pr[1] = w_dif[2] * w_add[0];
        w_pr[2] = w_dif[0] * w_add[1];
    end

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            w_side[k] = EXT_W'({r_max[k][COORD_W-1], r_max[k]} - {r_min[k][COORD_W-1], r_min[k]});
        end
        w_ext01 = (w_side[1] > w_side[0]) ? w_side[1] : w_side[0];
        w_ext   = (w_side[2] > w_ext01) ? w_side[2] : w_ext01;
    end

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            o_summary.normal[k] = r_sum[k];
        end
        o_summary.extent     = w_ext;
        o_summary.few        = (r_count < CNT_W'(MIN_VERTS));
        o_summary.overflowed = r_ovf;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_RUN: begin
                if (w_accept && i_last_vertex) n_state = F_CLOSE;
            end
            F_CLOSE: n_state = F_DRAIN;
            F_DRAIN: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) n_state = F_RUN;
            end
            default: n_state = F_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_RUN;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_prod_vld <= 1'b0;
            for (int k = 0; k < NUM_AXES; k++) r_sum[k] <= '0;
        end else begin
            r_state    <= n_state;
            r_prod_vld <= w_prod_en;
            if (o_push) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                for (int k = 0; k < NUM_AXES; k++) r_sum[k] <= '0;
            end else begin
                if (w_take) r_count <= r_count + CNT_W'(1);
                if (w_accept && w_cnt_full) r_ovf <= 1'b1;
                if (r_prod_vld) begin
                    for (int k = 0; k < NUM_AXES; k++) begin
                        r_sum[k] <= r_sum[k]
                            + {{(SUM_W-PROD_W){r_prod[k][PROD_W-1]}}, r_prod[k]};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_prod_en) begin
            for (int k = 0; k < NUM_AXES; k++) r_prod[k] <= w_pr[k];
        end
        if (w_take) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_prev[k] <= w_pt[k];
                if (r_count == '0) begin
                    r_first[k] <= w_pt[k];
                    r_min[k]   <= w_pt[k];
                    r_max[k]   <= w_pt[k];
                end else begin
                    if (w_pt[k] < r_min[k]) r_min[k] <= w_pt[k];
                    if (w_pt[k] > r_max[k]) r_max[k] <= w_pt[k];
                end
            end
        end
    end

endmodule

### rtl/pnd_queue.sv
// ----------------------------------------------------------------------------
// pnd_queue
// Small FIFO of ring summaries between the front end and the back end.
// ----------------------------------------------------------------------------
module pnd_queue import pnd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_summary i_data,
    output logic     o_full,
    input  logic     i_pop,
    output t_summary o_data,
    output logic     o_empty
);

    t_summary          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + (QPTR_W+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

### rtl/pnd_back.sv
// ----------------------------------------------------------------------------
// pnd_back
// Degeneracy test on one ring summary: |n|^2 * 2^64 < (tol * E^2)^2, built
// from partial products on one shared 32x32 multiplier, then the result.
// ----------------------------------------------------------------------------
module pnd_back import pnd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_summary                i_summary,
    input  logic                    i_empty,
    output logic                    o_pop,
    input  logic [TOL_W-1:0]        i_tol,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_normal_x,
    output logic signed [OUT_W-1:0] o_normal_y,
    output logic signed [OUT_W-1:0] o_normal_z,
    output logic                    o_degenerate,
    output logic                    o_too_long
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL  = 5'b00010,
        B_ACC  = 5'b00100,
        B_CMP  = 5'b01000,
        B_OUT  = 5'b10000
    } t_bstate;

    typedef enum logic [3:0] {
        PH_NORM = 4'b0001,
        PH_E2   = 4'b0010,
        PH_TOL  = 4'b0100,
        PH_SQ   = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        PART_LL = 3'b001,
        PART_LH = 3'b010,
        PART_HH = 3'b100
    } t_part;

    t_bstate             r_state;
    t_phase              r_phase;
    t_part               r_part;
    logic [AXIS_W-1:0]   r_comp;
    logic [SUM_W-1:0]    r_mag [NUM_AXES];
    logic [EXT_W-1:0]    r_ext;
    logic [MUL_W-1:0]    r_e2;
    logic [2*MUL_W-1:0]  r_t;
    logic [2*MUL_W-1:0]  r_pp;
    logic [NSQ_W-1:0]    r_acc_n;
    logic [RSQ_W-1:0]    r_acc_r;
    logic [OUT_W-1:0]    r_nrm [NUM_AXES];
    logic                r_deg;
    logic                r_long;

    logic [2*MUL_W-1:0]  w_wide;
    logic [MUL_W-1:0]    w_lo;
    logic [MUL_W-1:0]    w_hi;
    logic [MUL_W-1:0]    w_a;
    logic [MUL_W-1:0]    w_b;
    logic [2*MUL_W-1:0]  w_prod;
    logic [RSQ_W-1:0]    w_shifted;
    logic [2*MUL_W-1:0]  w_r_hi;
    logic [2*MUL_W-1:0]  w_r_lo;
    logic [NSQ_W-1:0]    w_r_hi_ext;
    logic                w_less;
    logic                w_skip;

    assign o_pop        = (r_state == B_IDLE) && !i_empty;
    assign o_valid      = (r_state == B_OUT);
    assign o_normal_x   = r_nrm[0];
    assign o_normal_y   = r_nrm[1];
    assign o_normal_z   = r_nrm[2];
    assign o_degenerate = r_deg;
    assign o_too_long   = r_long;

    assign w_skip = i_summary.overflowed || i_summary.few || (i_summary.extent == '0);

    always_comb begin
        w_wide = (r_phase == PH_SQ) ? r_t
                                    : {{(2*MUL_W-SUM_W){1'b0}}, r_mag[r_comp]};
        w_lo   = w_wide[MUL_W-1:0];
        w_hi   = w_wide[2*MUL_W-1:MUL_W];
        w_a    = w_lo;
        w_b    = w_lo;
        case (r_phase)
            PH_E2: begin
                w_a = {{(MUL_W-EXT_W){1'b0}}, r_ext};
                w_b = {{(MUL_W-EXT_W){1'b0}}, r_ext};
            end
            PH_TOL: begin
                w_a = i_tol;
                w_b = r_e2;
            end
            default: begin
                case (r_part)
                    PART_LH: begin
                        w_a = w_lo;
                        w_b = w_hi;
                    end
                    PART_HH: begin
                        w_a = w_hi;
                        w_b = w_hi;
                    end
                    default: begin
                        w_a = w_lo;
                        w_b = w_lo;
                    end
                endcase
            end
        endcase
        w_prod = w_a * w_b;
    end

    // cross term counted twice, hence one extra bit of shift
    always_comb begin
        case (r_part)
            PART_LH: w_shifted = {{(RSQ_W-2*MUL_W){1'b0}}, r_pp} << (MUL_W + 1);
            PART_HH: w_shifted = {{(RSQ_W-2*MUL_W){1'b0}}, r_pp} << (2 * MUL_W);
            default: w_shifted = {{(RSQ_W-2*MUL_W){1'b0}}, r_pp};
        endcase
    end

    assign w_r_hi     = r_acc_r[RSQ_W-1:2*MUL_W];
    assign w_r_lo     = r_acc_r[2*MUL_W-1:0];
    assign w_r_hi_ext = {{(NSQ_W-2*MUL_W){1'b0}}, w_r_hi};
    assign w_less     = (r_acc_n < w_r_hi_ext) || ((r_acc_n == w_r_hi_ext) && (w_r_lo != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_phase <= PH_NORM;
            r_part  <= PART_LL;
            r_comp  <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= w_skip ? B_OUT : B_MUL;
                        r_phase <= PH_NORM;
                        r_part  <= PART_LL;
                        r_comp  <= '0;
                    end
                end
                B_MUL: r_state <= B_ACC;
                B_ACC: begin
                    r_state <= B_MUL;
                    case (r_phase)
                        PH_NORM: begin
                            case (r_part)
                                PART_LL: r_part <= PART_LH;
                                PART_LH: r_part <= PART_HH;
                                default: begin
                                    r_part <= PART_LL;
                                    if (r_comp == LAST_AXIS) r_phase <= PH_E2;
                                    else r_comp <= r_comp + AXIS_W'(1);
                                end
                            endcase
                        end
                        PH_E2: r_phase <= PH_TOL;
                        PH_TOL: begin
                            r_phase <= PH_SQ;
                            r_part  <= PART_LL;
                        end
                        default: begin
                            case (r_part)
                                PART_LL: r_part <= PART_LH;
                                PART_LH: r_part <= PART_HH;
                                default: r_state <= B_CMP;
                            endcase
                        end
                    endcase
                end
                B_CMP: r_state <= B_OUT;
                B_OUT: begin
                    if (!i_stall) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_mag[k] <= i_summary.normal[k][SUM_W-1] ? (~i_summary.normal[k] + SUM_W'(1))
                                                         : i_summary.normal[k];
                r_nrm[k] <= i_summary.overflowed ? '0 : i_summary.normal[k][OUT_W-1:0];
            end
            r_ext   <= i_summary.extent;
            r_deg   <= w_skip;
            r_long  <= i_summary.overflowed;
            r_acc_n <= '0;
            r_acc_r <= '0;
        end
        if (r_state == B_MUL) r_pp <= w_prod;
        if (r_state == B_ACC) begin
            case (r_phase)
                PH_NORM: r_acc_n <= r_acc_n + w_shifted[NSQ_W-1:0];
                PH_E2:   r_e2 <= r_pp[MUL_W-1:0];
                PH_TOL:  r_t <= r_pp;
                default: r_acc_r <= r_acc_r + w_shifted;
            endcase
        end
        if (r_state == B_CMP) r_deg <= w_less;
    end

endmodule
